[design/ttp_pkg.sv]
package ttp_pkg;

    // Input coordinate and edge vector widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    // Product of a pair of edge components, and a sum of one such product per axis
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    // Magnitude of a dot or cross component, split in halves for squaring
    localparam int MAG_W   = PROD_W;
    localparam int HALF_W  = MAG_W / 2;
    // Dividend (squared magnitude), quotient, square root and its remainder
    localparam int NUM_W   = 2 * MAG_W;
    localparam int QUO_W   = MAG_W;
    localparam int ROOT_W  = QUO_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    // Flattened coordinate
    localparam int OUT_W   = COORD_W + 1;

    // Edge that becomes the x axis: start vertex, end vertex
    typedef enum logic [1:0] {
        EDGE_AB,
        EDGE_BC,
        EDGE_CA
    } t_edge;

    // Per-triangle control that travels alongside the wide datapath
    typedef struct packed {
        t_edge edge_sel;
        logic  neg;
        logic  degen;
    } t_side;

endpackage

[design/triangle_plane_projection.sv]
// Throughput: one triangle per cycle; busy stays low, set by a fully pipelined datapath
// (5 setup stages, 4 squaring stages, a 67-stage divider, a 34-stage square root, 1 output).
// Reset (synchronous, active low) clears every valid bit and sets axis_choice to 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
module triangle_plane_projection
    import ttp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    input  logic signed [COORD_W-1:0] i_a_x,
    input  logic signed [COORD_W-1:0] i_a_y,
    input  logic signed [COORD_W-1:0] i_a_z,
    input  logic signed [COORD_W-1:0] i_b_x,
    input  logic signed [COORD_W-1:0] i_b_y,
    input  logic signed [COORD_W-1:0] i_b_z,
    input  logic signed [COORD_W-1:0] i_c_x,
    input  logic signed [COORD_W-1:0] i_c_y,
    input  logic signed [COORD_W-1:0] i_c_z,
    output logic                      o_valid,
    output logic        [OUT_W-1:0]   o_out_a_x,
    output logic        [OUT_W-1:0]   o_out_a_y,
    output logic        [OUT_W-1:0]   o_out_b_x,
    output logic        [OUT_W-1:0]   o_out_b_y,
    output logic        [OUT_W-1:0]   o_out_c_x,
    output logic        [OUT_W-1:0]   o_out_c_y,
    output logic                      o_degenerate
);

    logic                      r_axis_choice;
    logic signed [COORD_W-1:0] w_vtx [0:2][0:2];

    logic                      fr_valid;
    t_edge                     fr_edge;
    logic        [MAG_W-1:0]   fr_aa;
    logic signed [SUM_W-1:0]   fr_ab;
    logic signed [SUM_W-1:0]   fr_n [0:2];

    logic                      sq_valid;
    t_side                     sq_side;
    logic        [MAG_W-1:0]   sq_aa;
    logic        [NUM_W-1:0]   sq_num [0:1];

    logic                      dv_valid;
    t_side                     dv_side;
    logic        [MAG_W-1:0]   dv_den;
    logic        [QUO_W-1:0]   dv_quo [0:1];
    logic        [QUO_W-1:0]   dv_rad [0:2];

    logic                      rt_valid;
    t_side                     rt_side;
    logic        [ROOT_W-1:0]  rt_root [0:2];

    logic        [OUT_W-1:0]   v_len, v_rxm, v_ry, v_px, v_qx, v_rx;
    logic        [OUT_W-1:0]   n_pos [0:2][0:1];
    logic        [OUT_W-1:0]   r_pos [0:2][0:1];
    logic                      r_valid, r_degen;

    // The pipeline never holds off a start beat
    assign busy = 1'b0;

    // Hold the axis selection register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_choice <= 1'b1;
        end else if (i_cfg_we) begin
            r_axis_choice <= i_cfg_wdata;
        end
    end

    assign w_vtx[0][0] = i_a_x;
    assign w_vtx[0][1] = i_a_y;
    assign w_vtx[0][2] = i_a_z;
    assign w_vtx[1][0] = i_b_x;
    assign w_vtx[1][1] = i_b_y;
    assign w_vtx[1][2] = i_b_z;
    assign w_vtx[2][0] = i_c_x;
    assign w_vtx[2][1] = i_c_y;
    assign w_vtx[2][2] = i_c_z;

    ttp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_axis_choice (r_axis_choice),
        .i_vtx         (w_vtx),
        .o_valid       (fr_valid),
        .o_edge        (fr_edge),
        .o_aa          (fr_aa),
        .o_ab          (fr_ab),
        .o_n           (fr_n)
    );

    ttp_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_edge  (fr_edge),
        .i_aa    (fr_aa),
        .i_ab    (fr_ab),
        .i_n     (fr_n),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_aa    (sq_aa),
        .o_ab2   (sq_num[0]),
        .o_nn    (sq_num[1])
    );

    ttp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_den   (sq_aa),
        .i_num   (sq_num),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_den   (dv_den),
        .o_quo   (dv_quo)
    );

    // Roots of |a|^2, (a.b)^2/|a|^2 and |a x b|^2/|a|^2
    assign dv_rad[0] = dv_den;
    assign dv_rad[1] = dv_quo[0];
    assign dv_rad[2] = dv_quo[1];

    ttp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_rad   (dv_rad),
        .o_valid (rt_valid),
        .o_side  (rt_side),
        .o_root  (rt_root)
    );

    // Place the edge start, edge end and third vertex, shifted so min x is zero
    always_comb begin
        v_len = OUT_W'(rt_root[0]);
        v_rxm = OUT_W'(rt_root[1]);
        v_ry  = OUT_W'(rt_root[2]);
        v_px  = rt_side.neg ? v_rxm : '0;
        v_qx  = v_len + v_px;
        v_rx  = rt_side.neg ? '0 : v_rxm;
        unique case (rt_side.edge_sel)
            EDGE_BC: begin
                n_pos[1][0] = v_px;
                n_pos[1][1] = '0;
                n_pos[2][0] = v_qx;
                n_pos[2][1] = '0;
                n_pos[0][0] = v_rx;
                n_pos[0][1] = v_ry;
            end
            EDGE_CA: begin
                n_pos[2][0] = v_px;
                n_pos[2][1] = '0;
                n_pos[0][0] = v_qx;
                n_pos[0][1] = '0;
                n_pos[1][0] = v_rx;
                n_pos[1][1] = v_ry;
            end
            default: begin
                n_pos[0][0] = v_px;
                n_pos[0][1] = '0;
                n_pos[1][0] = v_qx;
                n_pos[1][1] = '0;
                n_pos[2][0] = v_rx;
                n_pos[2][1] = v_ry;
            end
        endcase
        // Drop coordinates of a zero-area triangle
        if (rt_side.degen) begin
            for (int v = 0; v < 3; v++) begin
                n_pos[v][0] = '0;
                n_pos[v][1] = '0;
            end
        end
    end

    // Output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= rt_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_degen <= rt_side.degen;
    end

    assign o_valid      = r_valid;
    assign o_out_a_x    = r_pos[0][0];
    assign o_out_a_y    = r_pos[0][1];
    assign o_out_b_x    = r_pos[1][0];
    assign o_out_b_y    = r_pos[1][1];
    assign o_out_c_x    = r_pos[2][0];
    assign o_out_c_y    = r_pos[2][1];
    assign o_degenerate = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_out_a_x == '0 && o_out_a_y == '0 && o_out_b_x == '0 &&
            o_out_b_y == '0 && o_out_c_x == '0 && o_out_c_y == '0)
        else $error("degenerate result carries nonzero coordinates");

    a_min_x_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_a_x == '0 || o_out_b_x == '0 || o_out_c_x == '0)
        else $error("no vertex sits at x zero");

    a_one_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_out_a_y != '0, o_out_b_y != '0, o_out_c_y != '0}) <= 1)
        else $error("more than one vertex off the x axis");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("start beat refused");

endmodule

[design/ttp_front.sv]
module ttp_front
    import ttp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_axis_choice,
    input  logic signed [COORD_W-1:0] i_vtx [0:2][0:2],
    output logic                     o_valid,
    output t_edge                    o_edge,
    output logic        [MAG_W-1:0]  o_aa,
    output logic signed [SUM_W-1:0]  o_ab,
    output logic signed [SUM_W-1:0]  o_n [0:2]
);

    logic [4:0] r_vld;

    logic                     r_mode1, r_mode2;
    logic signed [COORD_W-1:0] r_vtx [0:2][0:2];
    logic signed [DIFF_W-1:0]  r_e [0:2][0:2];
    logic signed [DIFF_W-1:0]  n_e [0:2][0:2];
    t_edge                    r_edge3, r_edge4, r_edge5;
    t_edge                    n_edge;
    logic signed [DIFF_W-1:0]  r_a [0:2];
    logic signed [DIFF_W-1:0]  r_b [0:2];
    logic signed [DIFF_W-1:0]  n_a [0:2];
    logic signed [DIFF_W-1:0]  n_b [0:2];
    logic signed [PROD_W-1:0]  r_sq [0:2];
    logic signed [PROD_W-1:0]  r_x [0:2][0:2];
    logic        [MAG_W-1:0]  r_aa;
    logic signed [SUM_W-1:0]  r_ab;
    logic signed [SUM_W-1:0]  r_n [0:2];
    logic signed [SUM_W-1:0]  n_aa_full;
    logic signed [SUM_W-1:0]  n_ab;
    logic signed [SUM_W-1:0]  n_n [0:2];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Stage 1: capture the beat
    always_ff @(posedge i_clk) begin
        r_mode1 <= i_axis_choice;
        r_vtx   <= i_vtx;
    end

    // Stage 2: form the edge vectors AB, BC and CA
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[0][i] = DIFF_W'(r_vtx[1][i]) - DIFF_W'(r_vtx[0][i]);
            n_e[1][i] = DIFF_W'(r_vtx[2][i]) - DIFF_W'(r_vtx[1][i]);
            n_e[2][i] = DIFF_W'(r_vtx[0][i]) - DIFF_W'(r_vtx[2][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode2 <= r_mode1;
        r_e     <= n_e;
    end

    // Stage 3: pick the x-axis edge (AB when axis_choice is 0, else the largest x component), ties go to AB then BC
    always_comb begin
        if (!r_mode2 || (r_e[0][0] >= r_e[1][0] && r_e[0][0] >= r_e[2][0])) begin
            n_edge = EDGE_AB;
        end else if (r_e[1][0] >= r_e[2][0]) begin
            n_edge = EDGE_BC;
        end else begin
            n_edge = EDGE_CA;
        end
        for (int i = 0; i < 3; i++) begin
            unique case (n_edge)
                EDGE_BC: begin
                    n_a[i] = r_e[1][i];
                    n_b[i] = -r_e[0][i];
                end
                EDGE_CA: begin
                    n_a[i] = r_e[2][i];
                    n_b[i] = -r_e[1][i];
                end
                default: begin
                    n_a[i] = r_e[0][i];
                    n_b[i] = -r_e[2][i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge3 <= n_edge;
        r_a     <= n_a;
        r_b     <= n_b;
    end

    // Stage 4: all component products
    always_ff @(posedge i_clk) begin
        r_edge4 <= r_edge3;
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= PROD_W'(r_a[i]) * PROD_W'(r_a[i]);
            for (int j = 0; j < 3; j++) begin
                r_x[i][j] <= PROD_W'(r_a[i]) * PROD_W'(r_b[j]);
            end
        end
    end

    // Stage 5: |a|^2, a.b and a x b
    always_comb begin
        n_aa_full = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        n_ab      = SUM_W'(r_x[0][0]) + SUM_W'(r_x[1][1]) + SUM_W'(r_x[2][2]);
        n_n[0]    = SUM_W'(r_x[1][2]) - SUM_W'(r_x[2][1]);
        n_n[1]    = SUM_W'(r_x[2][0]) - SUM_W'(r_x[0][2]);
        n_n[2]    = SUM_W'(r_x[0][1]) - SUM_W'(r_x[1][0]);
    end

    always_ff @(posedge i_clk) begin
        r_edge5 <= r_edge4;
        r_aa    <= n_aa_full[MAG_W-1:0];
        r_ab    <= n_ab;
        r_n     <= n_n;
    end

    assign o_valid = r_vld[4];
    assign o_edge  = r_edge5;
    assign o_aa    = r_aa;
    assign o_ab    = r_ab;
    assign o_n     = r_n;

endmodule

[design/ttp_sq.sv]
module ttp_sq
    import ttp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_edge                   i_edge,
    input  logic        [MAG_W-1:0] i_aa,
    input  logic signed [SUM_W-1:0] i_ab,
    input  logic signed [SUM_W-1:0] i_n [0:2],
    output logic                    o_valid,
    output t_side                   o_side,
    output logic        [MAG_W-1:0] o_aa,
    output logic        [NUM_W-1:0] o_ab2,
    output logic        [NUM_W-1:0] o_nn
);

    logic [3:0] r_vld;

    t_side                   r_side1, r_side2, r_side3, r_side4;
    logic        [MAG_W-1:0] r_aa1, r_aa2, r_aa3, r_aa4;
    logic signed [SUM_W-1:0] n_val [0:3];
    logic        [MAG_W-1:0] n_mag [0:3];
    logic        [MAG_W-1:0] r_mag [0:3];
    logic        [MAG_W-1:0] r_hh [0:3];
    logic        [MAG_W-1:0] r_hl [0:3];
    logic        [MAG_W-1:0] r_ll [0:3];
    logic        [NUM_W-1:0] r_sq [0:3];
    logic        [NUM_W-1:0] r_ab2, r_nn;
    logic signed [SUM_W-1:0] v_abs;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Stage A: magnitudes of the three cross components and the dot product
    always_comb begin
        n_val[0] = i_n[0];
        n_val[1] = i_n[1];
        n_val[2] = i_n[2];
        n_val[3] = i_ab;
        for (int l = 0; l < 4; l++) begin
            v_abs    = n_val[l][SUM_W-1] ? -n_val[l] : n_val[l];
            n_mag[l] = v_abs[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side1.edge_sel <= i_edge;
        r_side1.neg      <= i_ab[SUM_W-1];
        r_side1.degen    <= (i_n[0] == '0) && (i_n[1] == '0) && (i_n[2] == '0);
        r_aa1            <= i_aa;
        r_mag            <= n_mag;
    end

    // Stage B: half-width partial products of each square
    always_ff @(posedge i_clk) begin
        r_side2 <= r_side1;
        r_aa2   <= r_aa1;
        for (int l = 0; l < 4; l++) begin
            r_hh[l] <= MAG_W'(r_mag[l][MAG_W-1:HALF_W]) * MAG_W'(r_mag[l][MAG_W-1:HALF_W]);
            r_hl[l] <= MAG_W'(r_mag[l][MAG_W-1:HALF_W]) * MAG_W'(r_mag[l][HALF_W-1:0]);
            r_ll[l] <= MAG_W'(r_mag[l][HALF_W-1:0]) * MAG_W'(r_mag[l][HALF_W-1:0]);
        end
    end

    // Stage C: merge partials into full squares
    always_ff @(posedge i_clk) begin
        r_side3 <= r_side2;
        r_aa3   <= r_aa2;
        for (int l = 0; l < 4; l++) begin
            r_sq[l] <= (NUM_W'(r_hh[l]) << MAG_W) + (NUM_W'(r_hl[l]) << (HALF_W + 1))
                     + NUM_W'(r_ll[l]);
        end
    end

    // Stage D: |a x b|^2, with (a.b)^2 passed on
    always_ff @(posedge i_clk) begin
        r_side4 <= r_side3;
        r_aa4   <= r_aa3;
        r_nn    <= r_sq[0] + r_sq[1] + r_sq[2];
        r_ab2   <= r_sq[3];
    end

    assign o_valid = r_vld[3];
    assign o_side  = r_side4;
    assign o_aa    = r_aa4;
    assign o_ab2   = r_ab2;
    assign o_nn    = r_nn;

endmodule

[design/ttp_div.sv]
module ttp_div
    import ttp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [MAG_W-1:0] i_den,
    input  logic [NUM_W-1:0] i_num [0:1],
    output logic             o_valid,
    output t_side            o_side,
    output logic [MAG_W-1:0] o_den,
    output logic [QUO_W-1:0] o_quo [0:1]
);

    logic [QUO_W:0]   r_vld;
    t_side            r_side [0:QUO_W];
    logic [MAG_W-1:0] r_den  [0:QUO_W];
    logic [MAG_W-1:0] r_rem  [0:QUO_W][0:1];
    logic [QUO_W-1:0] r_low  [0:QUO_W][0:1];
    logic [QUO_W-1:0] r_quo  [0:QUO_W][0:1];
    logic [MAG_W-1:0] n_rem  [0:QUO_W-1][0:1];
    logic [QUO_W-1:0] n_low  [0:QUO_W-1][0:1];
    logic [QUO_W-1:0] n_quo  [0:QUO_W-1][0:1];
    logic [MAG_W:0]   v_sh;
    logic [MAG_W+1:0] v_df;
    logic             v_ge;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QUO_W-1:0], i_valid};
        end
    end

    // One quotient bit per stage; the upper dividend half is already below the divisor
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            for (int l = 0; l < 2; l++) begin
                v_sh = {r_rem[k][l], r_low[k][l][QUO_W-1]};
                v_df = {1'b0, v_sh} - {2'b00, r_den[k]};
                v_ge = !v_df[MAG_W+1];
                n_rem[k][l] = v_ge ? v_df[MAG_W-1:0] : v_sh[MAG_W-1:0];
                n_low[k][l] = {r_low[k][l][QUO_W-2:0], 1'b0};
                n_quo[k][l] = {r_quo[k][l][QUO_W-2:0], v_ge};
            end
        end
    end

    // Load the beat, then shift it through the stages
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_den[0]  <= i_den;
        for (int l = 0; l < 2; l++) begin
            r_rem[0][l] <= i_num[l][NUM_W-1:QUO_W];
            r_low[0][l] <= i_num[l][QUO_W-1:0];
            r_quo[0][l] <= '0;
        end
        for (int k = 0; k < QUO_W; k++) begin
            r_side[k+1] <= r_side[k];
            r_den[k+1]  <= r_den[k];
            r_rem[k+1]  <= n_rem[k];
            r_low[k+1]  <= n_low[k];
            r_quo[k+1]  <= n_quo[k];
        end
    end

    assign o_valid  = r_vld[QUO_W];
    assign o_side   = r_side[QUO_W];
    assign o_den    = r_den[QUO_W];
    assign o_quo[0] = r_quo[QUO_W][0];
    assign o_quo[1] = r_quo[QUO_W][1];

endmodule

[design/ttp_sqrt.sv]
module ttp_sqrt
    import ttp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [QUO_W-1:0]  i_rad  [0:2],
    output logic              o_valid,
    output t_side             o_side,
    output logic [ROOT_W-1:0] o_root [0:2]
);

    logic [ROOT_W:0]   r_vld;
    t_side             r_side [0:ROOT_W];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W][0:2];
    logic [QUO_W-1:0]  r_x    [0:ROOT_W][0:2];
    logic [ROOT_W-1:0] r_root [0:ROOT_W][0:2];
    logic [REM_W-1:0]  n_rem  [0:ROOT_W-1][0:2];
    logic [QUO_W-1:0]  n_x    [0:ROOT_W-1][0:2];
    logic [ROOT_W-1:0] n_root [0:ROOT_W-1][0:2];
    logic [REM_W+1:0]  v_sh;
    logic [REM_W+2:0]  v_df;
    logic              v_ge;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-1:0], i_valid};
        end
    end

    // One root bit per stage from the next two radicand bits
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            for (int l = 0; l < 3; l++) begin
                v_sh = {r_rem[k][l], r_x[k][l][QUO_W-1:QUO_W-2]};
                v_df = {1'b0, v_sh} - {2'b00, r_root[k][l], 2'b01};
                v_ge = !v_df[REM_W+2];
                n_rem[k][l]  = v_ge ? v_df[REM_W-1:0] : v_sh[REM_W-1:0];
                n_x[k][l]    = {r_x[k][l][QUO_W-3:0], 2'b00};
                n_root[k][l] = {r_root[k][l][ROOT_W-2:0], v_ge};
            end
        end
    end

    // Load the beat, then shift it through the stages
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l]  <= '0;
            r_x[0][l]    <= i_rad[l];
            r_root[0][l] <= '0;
        end
        for (int k = 0; k < ROOT_W; k++) begin
            r_side[k+1] <= r_side[k];
            r_rem[k+1]  <= n_rem[k];
            r_x[k+1]    <= n_x[k];
            r_root[k+1] <= n_root[k];
        end
    end

    assign o_valid   = r_vld[ROOT_W];
    assign o_side    = r_side[ROOT_W];
    assign o_root[0] = r_root[ROOT_W][0];
    assign o_root[1] = r_root[ROOT_W][1];
    assign o_root[2] = r_root[ROOT_W][2];

endmodule
